>>> hw/rtl/hfl_pkg.sv
// shared types, constants and log-domain arithmetic for the hmm forward block
`timescale 1ns / 1ps
package hfl_pkg;

    localparam int MAX_STATES = 16;
    localparam int IDX_W      = $clog2(MAX_STATES);
    localparam int CNT_W      = $clog2(MAX_STATES + 1);
    localparam int TR_DEPTH   = MAX_STATES * MAX_STATES;
    localparam int VAL_W      = 32;
    localparam int LN_SHIFT   = 15;
    localparam int LN_ENTRIES = 24;

    localparam logic signed [VAL_W-1:0] NEG_INF = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    typedef logic signed [VAL_W-1:0] t_val;

    typedef enum logic [1:0] {
        MODE_TRANS = 2'd0,
        MODE_INIT  = 2'd1,
        MODE_EMIT  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic KIND_ALPHA = 1'b0;
    localparam logic KIND_LIK   = 1'b1;

    // ln(1+e^-x) at bin midpoints, bins 0.5 wide
    function automatic t_val ln_corr(input logic [4:0] idx);
        t_val c;
        case (idx)
            5'd0:  c = 32'sd37745;
            5'd1:  c = 32'sd25354;
            5'd2:  c = 32'sd16511;
            5'd3:  c = 32'sd10501;
            5'd4:  c = 32'sd6567;
            5'd5:  c = 32'sd4061;
            5'd6:  c = 32'sd2493;
            5'd7:  c = 32'sd1523;
            5'd8:  c = 32'sd928;
            5'd9:  c = 32'sd565;
            5'd10: c = 32'sd343;
            5'd11: c = 32'sd208;
            5'd12: c = 32'sd126;
            5'd13: c = 32'sd77;
            5'd14: c = 32'sd47;
            5'd15: c = 32'sd28;
            5'd16: c = 32'sd17;
            5'd17: c = 32'sd10;
            5'd18: c = 32'sd6;
            5'd19: c = 32'sd4;
            5'd20: c = 32'sd2;
            5'd21: c = 32'sd1;
            5'd22: c = 32'sd1;
            5'd23: c = 32'sd1;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic t_val sat32(input logic signed [VAL_W:0] v);
        t_val r;
        if (v > $signed({1'b0, POS_MAX}))
            r = POS_MAX;
        else if (v < $signed({1'b1, NEG_INF}))
            r = NEG_INF;
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

    // product of probabilities: sum of logs
    function automatic t_val log_mul(input t_val a, input t_val b);
        t_val r;
        if (a == NEG_INF || b == NEG_INF)
            r = NEG_INF;
        else
            r = sat32({a[VAL_W-1], a} + {b[VAL_W-1], b});
        return r;
    endfunction

    // sum of probabilities: max plus table correction
    function automatic t_val log_add(input t_val a, input t_val b);
        t_val                    hi;
        t_val                    lo;
        logic        [VAL_W:0]   d;
        t_val                    corr;
        t_val                    r;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        d    = {hi[VAL_W-1], hi} - {lo[VAL_W-1], lo};
        corr = '0;
        if (d < (VAL_W+1)'(LN_ENTRIES << LN_SHIFT))
            corr = ln_corr(d[LN_SHIFT+4:LN_SHIFT]);
        if (a == NEG_INF)
            r = b;
        else if (b == NEG_INF)
            r = a;
        else
            r = sat32({hi[VAL_W-1], hi} + {corr[VAL_W-1], corr});
        return r;
    endfunction

endpackage

>>> hw/rtl/hfl_ram.sv
// generic single-write, single-read memory with registered read data
`timescale 1ns / 1ps
module hfl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> hw/rtl/hfl_lse.sv
// shared log-add accumulator, one term a cycle while enabled
`timescale 1ns / 1ps
module hfl_lse
    import hfl_pkg::*;
(
    input  logic i_clk,
    input  logic i_clr,
    input  logic i_en,
    input  t_val i_term,
    output t_val o_acc
);

    t_val r_acc;
    t_val n_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_clr)
            n_acc = NEG_INF;
        else if (i_en)
            n_acc = log_add(r_acc, i_term);
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

>>> hw/rtl/hmm_forward_log_space.sv
// top level: log-domain hmm forward recursion with one shared log-add unit
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------
//  input    | i_valid / o_ready        | i_mode i_from_state i_to_state i_log_value
//           |                          | i_start_sequence i_end_sequence
//  output   | o_valid / i_ready        | o_kind o_state_index o_log_result o_last
//  config   | psel penable pwrite      | paddr pwdata prdata (num_states at 0)
//
// a load word is written as it is taken; a first-step emission goes
// straight to the write state, a later-step one first accumulates:
// the transition memory read port feeds the log-add unit one term a cycle
// the final state of a closing step then also sums the likelihood
// o_ready is high only when idle; a stalled result just holds the block
// synchronous active-low reset clears control state and sets num_states to 16
`timescale 1ns / 1ps
module hmm_forward_log_space
    import hfl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [IDX_W-1:0]  i_from_state,
    input  logic [IDX_W-1:0]  i_to_state,
    input  logic signed [31:0] i_log_value,
    input  logic              i_start_sequence,
    input  logic              i_end_sequence,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [IDX_W-1:0]  o_state_index,
    output logic signed [31:0] o_log_result,
    output logic              o_last,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_WR,
        S_OUT,
        S_LIK,
        S_LOUT,
        S_LWAIT
    } t_state;

    t_state r_state;

    // config register
    logic [4:0]       r_num_states;
    logic [CNT_W-1:0] n_use;

    // latched word
    logic [IDX_W-1:0] r_to;
    t_val             r_val;
    logic             r_end;

    // tables held in flops: initial, previous and current forward values
    t_val r_init [MAX_STATES];
    t_val r_prev [MAX_STATES];
    t_val r_cur  [MAX_STATES];

    // sequencer
    logic [CNT_W-1:0] r_cnt;
    logic             r_v1;     // memory data and r_pa valid
    logic             r_v2;     // r_term valid
    t_val             r_pa;
    t_val             r_term;
    t_val             r_alpha;

    logic             in_acc;
    logic             last_st;
    logic             tr_we;
    t_val             tr_q;
    logic             lse_clr;
    logic             lse_en;
    t_val             lse_term;
    t_val             lse_acc;

    // effective state count clamped to one..max
    always_comb begin
        if (r_num_states == 5'd0)
            n_use = CNT_W'(1);
        else if (32'(r_num_states) > MAX_STATES)
            n_use = CNT_W'(MAX_STATES);
        else
            n_use = CNT_W'(r_num_states);
    end

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == 1'b0) ? {27'd0, r_num_states} : 32'd0;
    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    assign last_st = (CNT_W'(r_to) + CNT_W'(1)) == n_use;
    assign tr_we   = in_acc && (i_mode == MODE_TRANS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 5'd16;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_num_states <= pwdata[4:0];
        end
    end

    // transition matrix, row-major on {from, to}
    hfl_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TR_DEPTH)
    ) u_trans (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr ({i_from_state, i_to_state}),
        .i_wdata (i_log_value),
        .i_raddr ({r_cnt[IDX_W-1:0], r_to}),
        .o_rdata (tr_q)
    );

    // shared log-add: fed by the transition products, then by the current values
    always_comb begin
        lse_clr  = in_acc || (r_state == S_OUT && i_ready);
        lse_en   = 1'b0;
        lse_term = r_term;
        if (r_state == S_MAC) begin
            lse_en = r_v2;
        end else if (r_state == S_LIK) begin
            lse_en   = (r_cnt < n_use);
            lse_term = r_cur[r_cnt[IDX_W-1:0]];
        end
    end

    hfl_lse u_lse (
        .i_clk  (i_clk),
        .i_clr  (lse_clr),
        .i_en   (lse_en),
        .i_term (lse_term),
        .o_acc  (lse_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_cnt   <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_to  <= i_to_state;
                        r_val <= i_log_value;
                        r_end <= i_end_sequence;
                        r_cnt <= '0;
                        r_v1  <= 1'b0;
                        r_v2  <= 1'b0;
                        if (i_mode == MODE_INIT) begin
                            r_init[i_to_state] <= i_log_value;
                        end
                        if (i_mode == MODE_EMIT && CNT_W'(i_to_state) < n_use) begin
                            if (i_start_sequence) begin
                                r_alpha <= log_mul(r_init[i_to_state], i_log_value);
                                r_state <= S_WR;
                            end else begin
                                r_state <= S_MAC;
                            end
                        end
                    end
                end
                S_MAC: begin
                    // issue read, form product, accumulate: three-deep pipe
                    if (r_cnt < n_use) begin
                        r_pa  <= r_prev[r_cnt[IDX_W-1:0]];
                        r_cnt <= r_cnt + CNT_W'(1);
                        r_v1  <= 1'b1;
                    end else begin
                        r_v1  <= 1'b0;
                    end
                    r_v2 <= r_v1;
                    if (r_v1) begin
                        r_term <= log_mul(r_pa, tr_q);
                    end
                    if (r_cnt == n_use && !r_v1 && !r_v2) begin
                        r_alpha <= log_mul(r_val, lse_acc);
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_cur[r_to]   <= r_alpha;
                    o_valid       <= 1'b1;
                    o_kind        <= KIND_ALPHA;
                    o_state_index <= r_to;
                    o_log_result  <= r_alpha;
                    o_last        <= !(last_st && r_end);
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_cnt   <= '0;
                        if (last_st && r_end) begin
                            r_state <= S_LIK;
                        end else begin
                            if (last_st) begin
                                r_prev <= r_cur;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_LIK: begin
                    if (r_cnt < n_use) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end else begin
                        r_state <= S_LOUT;
                    end
                end
                S_LOUT: begin
                    o_valid       <= 1'b1;
                    o_kind        <= KIND_LIK;
                    o_state_index <= '0;
                    o_log_result  <= lse_acc;
                    o_last        <= 1'b1;
                    r_prev        <= r_cur;
                    r_state       <= S_LWAIT;
                end
                S_LWAIT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    o_valid <= 1'b0;
                end
            endcase
        end
    end

    // no word taken while a result is still on show
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input ready while a result is pending");

    // the likelihood is always the closing word with index zero
    a_lik_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_LIK) |-> (o_last && o_state_index == '0))
        else $error("likelihood word malformed");

    // a forward value not marked last must be followed by the likelihood
    a_alpha_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_kind == KIND_ALPHA && !o_last) |=> (r_state == S_LIK))
        else $error("likelihood not started after final forward value");

endmodule

>>> dv/hmm_forward_log_space_test.sv
// testbench for the log-domain hmm forward block: self-checking, random traffic
`timescale 1ns / 1ps
module hmm_forward_log_space_test;
    import hfl_pkg::*;

    // one forward value or likelihood as the block should give it
    typedef struct {
        logic       kind;
        logic [3:0] idx;
        t_val       value;
        logic       last;
    } t_alpha_word;

    // forward recursion predictor plus queue of pending results
    class alpha_scoreboard;
        int          corr_tab[24] = '{37745, 25354, 16511, 10501, 6567, 4061, 2493, 1523,
                                      928, 565, 343, 208, 126, 77, 47, 28,
                                      17, 10, 6, 4, 2, 1, 1, 1};
        logic [4:0]  num_states = 5'd16;
        t_val        trans_lp[16][16];
        t_val        init_lp[16];
        t_val        prior_alpha[16];
        t_val        cur_alpha[16];
        bit          prev_ok[16];
        bit          cur_ok[16];
        t_alpha_word pending[$];
        int          errors = 0;

        function int n_used();
            if (num_states == 0) return 1;
            if (num_states > 16) return 16;
            return num_states;
        endfunction

        function t_val clamp_val(longint v);
            if (v > longint'(POS_MAX)) return POS_MAX;
            if (v < longint'(NEG_INF)) return NEG_INF;
            return t_val'(v);
        endfunction

        // product of probabilities
        function t_val prob_mul(t_val a, t_val b);
            if (a == NEG_INF || b == NEG_INF) return NEG_INF;
            return clamp_val(longint'(a) + longint'(b));
        endfunction

        // sum of probabilities with table correction
        function t_val prob_add(t_val a, t_val b);
            t_val   hi;
            t_val   lo;
            longint d;
            longint corr;
            if (a == NEG_INF) return b;
            if (b == NEG_INF) return a;
            hi   = (a > b) ? a : b;
            lo   = (a > b) ? b : a;
            d    = longint'(hi) - longint'(lo);
            corr = (d < (longint'(24) << 15)) ? corr_tab[d >> 15] : 0;
            return clamp_val(longint'(hi) + corr);
        endfunction

        // emissions never read a store entry that was never written
        function bit is_safe(t_mode m, logic [3:0] to, logic st);
            int n;
            n = n_used();
            if (m != MODE_EMIT || to >= n) return 1;
            if (!st)
                for (int i = 0; i < n; i++)
                    if (!prev_ok[i]) return 0;
            if (to == n - 1)
                for (int i = 0; i < n; i++)
                    if (i != to && !cur_ok[i]) return 0;
            return 1;
        endfunction

        function void push(logic kind, logic [3:0] idx, t_val v, logic last);
            t_alpha_word w;
            w.kind  = kind;
            w.idx   = idx;
            w.value = v;
            w.last  = last;
            pending.push_back(w);
        endfunction

        // returns 1 if the word does something
        function bit note_word(t_mode m, logic [3:0] fr, logic [3:0] to, t_val v,
                               logic st, logic en);
            int   n;
            t_val alpha;
            t_val acc;
            n = n_used();
            case (m)
                MODE_TRANS: begin
                    trans_lp[fr][to] = v;
                    return 1;
                end
                MODE_INIT: begin
                    init_lp[to] = v;
                    return 1;
                end
                MODE_EMIT: ;
                default: return 0;
            endcase
            if (to >= n) return 0;
            if (st) begin
                alpha = prob_mul(init_lp[to], v);
            end else begin
                acc = NEG_INF;
                for (int i = 0; i < n; i++)
                    acc = prob_add(acc, prob_mul(prior_alpha[i], trans_lp[i][to]));
                alpha = prob_mul(v, acc);
            end
            cur_alpha[to] = alpha;
            cur_ok[to]    = 1;
            if (to + 1 != n) begin
                push(KIND_ALPHA, to, alpha, 1'b1);
                return 1;
            end
            if (en) begin
                acc = NEG_INF;
                for (int i = 0; i < n; i++) acc = prob_add(acc, cur_alpha[i]);
                push(KIND_ALPHA, to, alpha, 1'b0);
                push(KIND_LIK, 4'd0, acc, 1'b1);
            end else begin
                push(KIND_ALPHA, to, alpha, 1'b1);
            end
            prior_alpha = cur_alpha;
            prev_ok     = cur_ok;
            return 1;
        endfunction

        function void check_result(logic kind, logic [3:0] idx, t_val v, logic last);
            t_alpha_word w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind %0d idx %0d value %0d",
                         $time, kind, idx, v);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (w.kind !== kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, w.kind, kind);
                errors++;
            end
            if (w.idx !== idx) begin
                $display("%0t: state_index expected %0d actual %0d", $time, w.idx, idx);
                errors++;
            end
            if (w.value !== v) begin
                $display("%0t: log_result expected %0d actual %0d", $time, w.value, v);
                errors++;
            end
            if (w.last !== last) begin
                $display("%0t: last expected %0d actual %0d", $time, w.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode           = MODE_NONE;
    logic [3:0]  i_from_state     = '0;
    logic [3:0]  i_to_state       = '0;
    t_val        i_log_value      = '0;
    logic        i_start_sequence = 1'b0;
    logic        i_end_sequence   = 1'b0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic        o_kind;
    logic [3:0]  o_state_index;
    t_val        o_log_result;
    logic        o_last;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [2:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;
    logic [31:0] prdata;
    logic        pready;

    alpha_scoreboard sb = new();
    int idle_pct   = 38;  // chance in a hundred that either side idles this cycle
    int words_sent = 0;
    int hold_left  = 0;
    bit hold_done  = 0;

    hmm_forward_log_space u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // generous cap on the whole run
    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: checks each accepted result word and throttles i_ready;
    // once, mid-run, it holds off for a long stretch so the block backs up
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result(o_kind, o_state_index, o_log_result, o_last);
        if (!hold_done && words_sent >= 450) begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // offer one word, idling at random first; returns once it is accepted
    task automatic send_word(t_mode m, logic [3:0] fr, logic [3:0] to, t_val v,
                             logic st, logic en, output bit useful);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_mode           <= m;
        i_from_state     <= fr;
        i_to_state       <= to;
        i_log_value      <= v;
        i_start_sequence <= st;
        i_end_sequence   <= en;
        do @(posedge i_clk); while (!o_ready);
        useful = sb.note_word(m, fr, to, v, st, en);
        words_sent++;
    endtask

    // log probabilities, half of them near zero, with the extremes and wide values mixed in
    function automatic t_val rand_log();
        case ($urandom_range(9))
            0: return NEG_INF;
            1: return POS_MAX;
            2: return t_val'($urandom);
            3: return NEG_INF + t_val'($urandom_range(1, 1 << 22));
            4: return POS_MAX - t_val'($urandom_range(0, 1 << 22));
            5: return t_val'($urandom_range(0, 4 << 16));
            default: return -t_val'($urandom_range(0, 12 << 16));
        endcase
    endfunction

    // wait until no result is outstanding, then for the block's own tail
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_num_states(logic [4:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= {27'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.num_states = v;
    endtask

    // random traffic: mostly whole sequences in state order, some noise
    task automatic run_phase(int count);
        int         done;
        int         n;
        int         seq_t;
        int         seq_len;
        int         seq_s;
        bit         useful;
        logic [3:0] to;
        logic       st;
        logic       en;
        done    = 0;
        seq_t   = 0;
        seq_s   = 0;
        seq_len = $urandom_range(1, 4);
        n       = sb.n_used();
        while (done < count) begin
            if ($urandom_range(99) < 85) begin
                to = seq_s;
                st = (seq_t == 0);
                en = (seq_t == seq_len - 1);
                if (!sb.is_safe(MODE_EMIT, to, st)) begin
                    seq_s = 0;
                    seq_t = 0;
                    send_word(MODE_NONE, 4'($urandom), 4'($urandom), rand_log(),
                              1'($urandom), 1'($urandom), useful);
                    continue;
                end
                send_word(MODE_EMIT, 4'($urandom), to, rand_log(), st, en, useful);
                seq_s++;
                if (seq_s == n) begin
                    seq_s = 0;
                    seq_t++;
                    if (seq_t == seq_len) begin
                        seq_t   = 0;
                        seq_len = $urandom_range(1, 4);
                    end
                end
            end else begin
                case ($urandom_range(4))
                    0: send_word(MODE_TRANS, 4'($urandom), 4'($urandom), rand_log(),
                                 1'($urandom), 1'($urandom), useful);
                    1: send_word(MODE_INIT, 4'($urandom), 4'($urandom), rand_log(),
                                 1'($urandom), 1'($urandom), useful);
                    2: send_word(MODE_NONE, 4'($urandom), 4'($urandom), rand_log(),
                                 1'($urandom), 1'($urandom), useful);
                    default: begin
                        // out-of-order emission, or one for a state past the count in use
                        to = 4'($urandom);
                        st = 1'($urandom);
                        if (!sb.is_safe(MODE_EMIT, to, st)) st = 1'b1;
                        if (!sb.is_safe(MODE_EMIT, to, st)) to = 4'(n - 2);
                        send_word(MODE_EMIT, 4'($urandom), to, rand_log(), st,
                                  1'($urandom), useful);
                    end
                endcase
            end
            if (useful) done++;
        end
        drain();
    endtask

    initial begin
        bit useful;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill both tables so no emission ever reads an unwritten entry
        for (int f = 0; f < 16; f++)
            for (int t = 0; t < 16; t++)
                send_word(MODE_TRANS, 4'(f), 4'(t), rand_log(), 1'b0, 1'b0, useful);
        for (int t = 0; t < 16; t++)
            send_word(MODE_INIT, 4'd0, 4'(t), rand_log(), 1'b0, 1'b0, useful);
        drain();

        // directed: three states, minus infinity and saturation on every path
        write_num_states(5'd3);
        send_word(MODE_TRANS, 4'd0, 4'd1, NEG_INF, 1'b0, 1'b0, useful);
        send_word(MODE_TRANS, 4'd1, 4'd1, POS_MAX, 1'b0, 1'b0, useful);
        send_word(MODE_INIT, 4'd0, 4'd2, POS_MAX, 1'b0, 1'b0, useful);
        send_word(MODE_INIT, 4'd0, 4'd0, NEG_INF, 1'b0, 1'b0, useful);
        send_word(MODE_EMIT, 4'd0, 4'd0, -32'sd65536, 1'b1, 1'b0, useful);
        send_word(MODE_EMIT, 4'd0, 4'd1, NEG_INF, 1'b1, 1'b0, useful);
        send_word(MODE_EMIT, 4'd0, 4'd2, POS_MAX, 1'b1, 1'b0, useful);
        send_word(MODE_EMIT, 4'd0, 4'd0, NEG_INF + 32'sd5, 1'b0, 1'b0, useful);
        send_word(MODE_EMIT, 4'd0, 4'd1, POS_MAX, 1'b0, 1'b0, useful);
        send_word(MODE_EMIT, 4'd0, 4'd2, 32'sd0, 1'b0, 1'b0, useful);
        send_word(MODE_EMIT, 4'd0, 4'd0, 32'sd0, 1'b0, 1'b1, useful);
        send_word(MODE_EMIT, 4'd0, 4'd1, -32'sd65536, 1'b0, 1'b1, useful);
        send_word(MODE_EMIT, 4'd0, 4'd2, NEG_INF, 1'b0, 1'b1, useful);
        // ignored words: unused mode, state past the count in use; then loads for state 15
        send_word(MODE_NONE, 4'd15, 4'd15, POS_MAX, 1'b1, 1'b1, useful);
        send_word(MODE_EMIT, 4'd0, 4'd15, 32'sd0, 1'b1, 1'b1, useful);
        send_word(MODE_TRANS, 4'd15, 4'd15, NEG_INF, 1'b0, 1'b0, useful);
        send_word(MODE_INIT, 4'd0, 4'd15, POS_MAX, 1'b0, 1'b0, useful);
        // one-step sequence: start and end on the same word
        send_word(MODE_EMIT, 4'd0, 4'd0, -32'sd131072, 1'b1, 1'b1, useful);
        send_word(MODE_EMIT, 4'd0, 4'd1, -32'sd32768, 1'b1, 1'b1, useful);
        send_word(MODE_EMIT, 4'd0, 4'd2, -32'sd1, 1'b1, 1'b1, useful);
        drain();

        // random phases over several state counts; zero and 31 clamp
        write_num_states(5'd1);
        run_phase(40);
        write_num_states(5'd0);
        run_phase(25);
        write_num_states(5'd31);
        run_phase(70);
        write_num_states(5'd5);
        run_phase(60);
        write_num_states(5'd16);
        idle_pct = 0;  // stretch with no idling on either side
        run_phase(70);
        idle_pct = 38;
        write_num_states(5'd2);
        run_phase(45);
        write_num_states(5'd7);
        run_phase(50);
        write_num_states(5'd16);
        run_phase(40);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/hfl_pkg.sv
hw/rtl/hfl_ram.sv
hw/rtl/hfl_lse.sv
hw/rtl/hmm_forward_log_space.sv
dv/hmm_forward_log_space_test.sv
